// File: design/dzsc_pkg.sv
// Shared constants and types for the dead-zone scroll camera.
package dzsc_pkg;

  // Default screen size in pixels.
  localparam int ScreenWDefault = 160;
  localparam int ScreenHDefault = 144;

  // Field widths.
  localparam int PosW   = 16;
  localparam int CamW   = 12;
  localparam int RegW   = 8;
  localparam int TileW  = 8;

  // Signed working width for the follow arithmetic: holds -255..4350.
  localparam int AccW   = 15;

  // Stream word widths.
  localparam int InDataW  = 32;
  localparam int OutDataW = 64;

  // Configuration register indexes.
  localparam int CfgIdxW = 3;
  typedef enum logic [CfgIdxW-1:0] {
    CFG_ZONE_RIGHT_X     = 3'd0,
    CFG_ZONE_BOTTOM_Y    = 3'd1,
    CFG_MAP_WIDTH_TILES  = 3'd2,
    CFG_MAP_HEIGHT_TILES = 3'd3,
    CFG_SCROLL_SUPPRESS  = 3'd4
  } cfg_idx_t;

  // Reset values of the configuration registers.
  localparam logic [RegW-1:0] ZoneRightReset  = 8'd140;
  localparam logic [RegW-1:0] ZoneBottomReset = 8'd124;

  // One result word before packing.
  typedef struct packed {
    logic [TileW-1:0] row_left_col;
    logic [TileW-1:0] row_index;
    logic             row_refresh;
    logic [TileW-1:0] col_top_row;
    logic [TileW-1:0] col_index;
    logic             col_refresh;
    logic             scroll_valid;
    logic [CamW-1:0]  scroll_y;
    logic [CamW-1:0]  scroll_x;
  } result_t;

endpackage

// File: design/dead_zone_scroll_camera_unit.sv
// Dead-zone scroll camera: follows a target, clamps to the map and flags tile edges.
// Pipeline: an accepted word is held in the input register, and its result then
// in the result register, from which it is offered on the output.
// Throughput: one word per cycle while the output is not stalled, set by the single
// follow-and-clamp pass between the input register and the result register; a
// stalled output holds one result while the input register holds the next word.
// Reset: rst is synchronous and active high; it empties both registers, sets the
// camera to zero and loads the configuration registers with their reset values.
module dead_zone_scroll_camera_unit #(
  parameter int SCREEN_W = dzsc_pkg::ScreenWDefault,
  parameter int SCREEN_H = dzsc_pkg::ScreenHDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  // Input stream. tdata: target_pos_x [15:0], target_pos_y [31:16].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [dzsc_pkg::InDataW-1:0]  s_tdata,
  // Output stream. tdata: scroll_x [11:0], scroll_y [23:12], scroll_valid [24],
  // col_refresh [25], col_index [33:26], col_top_row [41:34], row_refresh [42],
  // row_index [50:43], row_left_col [58:51], zero [63:59].
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [dzsc_pkg::OutDataW-1:0] m_tdata,
  // Configuration write port.
  input  logic                          cfg_we,
  input  logic [dzsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dzsc_pkg::RegW-1:0]     cfg_data
);

  localparam int CamW  = dzsc_pkg::CamW;
  localparam int PosW  = dzsc_pkg::PosW;
  localparam int RegW  = dzsc_pkg::RegW;
  localparam int TileW = dzsc_pkg::TileW;
  localparam int AccW  = dzsc_pkg::AccW;

  // Screen sizes as 8-bit values; their range is 0 to 255.
  localparam logic [RegW-1:0] ScreenW8 = RegW'(SCREEN_W);
  localparam logic [RegW-1:0] ScreenH8 = RegW'(SCREEN_H);

  // Configuration registers.
  logic [RegW-1:0] zone_right_x;
  logic [RegW-1:0] zone_bottom_y;
  logic [RegW-1:0] map_width_tiles;
  logic [RegW-1:0] map_height_tiles;
  logic            scroll_suppress;

  always_ff @(posedge clk) begin
    if (rst) begin
      zone_right_x     <= dzsc_pkg::ZoneRightReset;
      zone_bottom_y    <= dzsc_pkg::ZoneBottomReset;
      map_width_tiles  <= '0;
      map_height_tiles <= '0;
      scroll_suppress  <= 1'b0;
    end else if (cfg_we) begin
      // Indexes past the register list are dropped by the default arm.
      unique case (cfg_index)
        dzsc_pkg::CFG_ZONE_RIGHT_X:     zone_right_x     <= cfg_data;
        dzsc_pkg::CFG_ZONE_BOTTOM_Y:    zone_bottom_y    <= cfg_data;
        dzsc_pkg::CFG_MAP_WIDTH_TILES:  map_width_tiles  <= cfg_data;
        dzsc_pkg::CFG_MAP_HEIGHT_TILES: map_height_tiles <= cfg_data;
        dzsc_pkg::CFG_SCROLL_SUPPRESS:  scroll_suppress  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // One axis of the camera. The target is converted to whole pixels and its
  // signed distance from the camera is checked against the dead zone. Past
  // the far edge the camera drags the target along that edge; before the near
  // edge it backs up, but only while the camera is off zero. The result is
  // then clamped to the range from zero to the map size minus the screen,
  // where a map smaller than the screen pins the camera at zero.
  function automatic logic [CamW-1:0] follow_axis(
    input logic [CamW-1:0] cam,
    input logic [PosW-1:0] pos,
    input logic [RegW-1:0] zone,
    input logic [RegW-1:0] tiles,
    input logic [RegW-1:0] screen
  );
    logic signed [AccW-1:0] tgt;
    logic signed [AccW-1:0] c;
    logic signed [AccW-1:0] delta;
    logic signed [AccW-1:0] zs;
    logic signed [AccW-1:0] near_edge;
    logic signed [AccW-1:0] lim;
    tgt       = AccW'(pos[PosW-1:4]);
    c         = AccW'(cam);
    zs        = AccW'(zone);
    delta     = tgt - c;
    // A zone edge past the screen size makes the near edge negative.
    near_edge = AccW'(screen) - zs;
    lim       = AccW'({tiles, 3'b000}) - AccW'(screen);
    if (delta > zs) begin
      c = tgt - zs;
    end else if (delta < near_edge && cam != '0) begin
      c = tgt - near_edge;
    end
    if (c < 0) begin
      c = '0;
    end
    if (lim < 0) begin
      lim = '0;
    end
    if (c > lim) begin
      c = lim;
    end
    return c[CamW-1:0];
  endfunction

  // Input register and result register. The input register moves forward
  // whenever the result register is empty or is being drained, so a new word
  // can enter in the same cycle that a finished one leaves.
  logic            in_valid;
  logic [PosW-1:0] in_pos_x;
  logic [PosW-1:0] in_pos_y;
  logic            out_valid;
  dzsc_pkg::result_t out_res;
  logic            advance;

  // Camera state; it also serves as the previous position for edge checks.
  logic [CamW-1:0] cam_x;
  logic [CamW-1:0] cam_y;

  assign advance  = !out_valid || m_tready;
  assign s_tready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tready && s_tvalid) begin
      in_pos_x <= s_tdata[PosW-1:0];
      in_pos_y <= s_tdata[2*PosW-1:PosW];
    end
  end

  // Follow, clamp and tile-edge logic for the word in the input register.
  logic [CamW-1:0]   nx;
  logic [CamW-1:0]   ny;
  logic [CamW:0]     lead_x;
  logic [CamW:0]     lead_y;
  dzsc_pkg::result_t res_next;

  always_comb begin
    nx = follow_axis(cam_x, in_pos_x, zone_right_x, map_width_tiles, ScreenW8);
    ny = follow_axis(cam_y, in_pos_y, zone_bottom_y, map_height_tiles, ScreenH8);
    // The leading edge sits one screen ahead of the camera.
    lead_x = {1'b0, nx} + (CamW+1)'(ScreenW8);
    lead_y = {1'b0, ny} + (CamW+1)'(ScreenH8);

    res_next              = '0;
    res_next.scroll_x     = nx;
    res_next.scroll_y     = ny;
    res_next.scroll_valid = !scroll_suppress;

    // A change of tile column: moving forward reloads the leading column,
    // moving back reloads the trailing one. Index and start wrap at 8 bits.
    if (nx[CamW-1:3] != cam_x[CamW-1:3]) begin
      res_next.col_refresh = 1'b1;
      res_next.col_index   = (nx > cam_x) ? lead_x[TileW+2:3] : nx[TileW+2:3];
      res_next.col_top_row = ny[TileW+2:3];
    end
    if (ny[CamW-1:3] != cam_y[CamW-1:3]) begin
      res_next.row_refresh  = 1'b1;
      res_next.row_index    = (ny > cam_y) ? lead_y[TileW+2:3] : ny[TileW+2:3];
      res_next.row_left_col = nx[TileW+2:3];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      cam_x     <= '0;
      cam_y     <= '0;
    end else if (advance) begin
      out_valid <= in_valid;
      // The camera moves even when scrolling is suppressed.
      if (in_valid) begin
        cam_x <= nx;
        cam_y <= ny;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance && in_valid) begin
      out_res <= res_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = dzsc_pkg::OutDataW'(out_res);

  // The camera always matches the result waiting on the output.
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_res.scroll_x == cam_x && out_res.scroll_y == cam_y))
    else $error("camera state differs from the pending scroll position");

  // Without a column refresh its index and start row are zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.col_refresh) |->
      (out_res.col_index == '0 && out_res.col_top_row == '0))
    else $error("column fields set without a column refresh");

  // Without a row refresh its index and start column are zero.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_res.row_refresh) |->
      (out_res.row_index == '0 && out_res.row_left_col == '0))
    else $error("row fields set without a row refresh");

  // The input side only stalls while a word sits in the input register
  // behind a stalled result.
  assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> (in_valid && out_valid && !m_tready))
    else $error("input stalled without a full pipeline");

endmodule

// File: bench/dzsc_scroll_checker.sv
// Self-checking monitor for the dead-zone scroll camera: predicts every result word and compares it.
module dzsc_scroll_checker #(
  parameter int SCREEN_W = dzsc_pkg::ScreenWDefault,
  parameter int SCREEN_H = dzsc_pkg::ScreenHDefault
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  input  logic                          s_tready,
  // target_pos_x [15:0], target_pos_y [31:16]
  input  logic [dzsc_pkg::InDataW-1:0]  s_tdata,
  input  logic                          m_tvalid,
  input  logic                          m_tready,
  // scroll_x, scroll_y, scroll_valid, col_refresh, col_index, col_top_row,
  // row_refresh, row_index, row_left_col, then zero padding
  input  logic [dzsc_pkg::OutDataW-1:0] m_tdata,
  input  logic                          cfg_we,
  input  logic [dzsc_pkg::CfgIdxW-1:0]  cfg_index,
  input  logic [dzsc_pkg::RegW-1:0]     cfg_data,
  output int                            mismatch_count,
  output int                            words_pending
);

  localparam int RegW     = dzsc_pkg::RegW;
  localparam int CamW     = dzsc_pkg::CamW;
  localparam int PosW     = dzsc_pkg::PosW;
  localparam int TileW    = dzsc_pkg::TileW;
  localparam int OutDataW = dzsc_pkg::OutDataW;
  localparam int ResultW  = $bits(dzsc_pkg::result_t);

  // Shadow copy of the configuration and the camera.
  logic [RegW-1:0] zone_x, zone_y, map_w, map_h;
  logic            suppress;
  logic [CamW-1:0] cam_x, cam_y;
  logic [CamW-1:0] next_x, next_y;

  dzsc_pkg::result_t expected_scroll_q[$];
  dzsc_pkg::result_t want_word, got_word;

  // Dead-zone follow on one axis, then clamp to the map.
  function automatic logic [CamW-1:0] chase_axis(input logic [CamW-1:0] cam,
                                                 input logic [PosW-1:0] pos,
                                                 input logic [RegW-1:0] zone,
                                                 input logic [RegW-1:0] tiles,
                                                 input int screen);
    int target, cpos, gap, near_lim, top_lim;
    target   = int'(pos[PosW-1:4]);
    cpos     = int'(cam);
    gap      = target - cpos;
    // A zone wider than the screen makes this negative, which is intended.
    near_lim = screen - int'(zone);
    top_lim  = int'(tiles) * 8 - screen;
    if (gap > int'(zone)) begin
      cpos = target - int'(zone);
    end else if (gap < near_lim && cpos > 0) begin
      cpos = target - near_lim;
    end
    if (cpos < 0) cpos = 0;
    if (top_lim < 0) top_lim = 0;
    if (cpos > top_lim) cpos = top_lim;
    return cpos[CamW-1:0];
  endfunction

  // Leading edge when moving forward, trailing edge when moving back.
  function automatic void tile_refresh(input logic [CamW-1:0] prev,
                                       input logic [CamW-1:0] nxt,
                                       input int screen,
                                       output logic hit,
                                       output logic [TileW-1:0] idx);
    hit = (nxt[CamW-1:3] != prev[CamW-1:3]);
    if (!hit) begin
      idx = '0;
    end else if (nxt > prev) begin
      idx = TileW'((int'(nxt) + screen) >> 3);
    end else begin
      idx = nxt[TileW+2:3];
    end
  endfunction

  task automatic report(input string what, input logic [63:0] want, input logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= 40) begin
      $display("%0t: scroll word error on %s: expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      zone_x   = dzsc_pkg::ZoneRightReset;
      zone_y   = dzsc_pkg::ZoneBottomReset;
      map_w    = '0;
      map_h    = '0;
      suppress = 1'b0;
      cam_x    = '0;
      cam_y    = '0;
      expected_scroll_q.delete();
      words_pending <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dzsc_pkg::CFG_ZONE_RIGHT_X:     zone_x = cfg_data;
          dzsc_pkg::CFG_ZONE_BOTTOM_Y:    zone_y = cfg_data;
          dzsc_pkg::CFG_MAP_WIDTH_TILES:  map_w = cfg_data;
          dzsc_pkg::CFG_MAP_HEIGHT_TILES: map_h = cfg_data;
          dzsc_pkg::CFG_SCROLL_SUPPRESS:  suppress = cfg_data[0];
          default: ;
        endcase
      end

      // Compare before predicting: a word leaving now never belongs to one arriving now.
      if (m_tvalid && m_tready) begin
        got_word = dzsc_pkg::result_t'(m_tdata[ResultW-1:0]);
        if (expected_scroll_q.size() == 0) begin
          report("word with nothing expected", '0, m_tdata);
        end else begin
          want_word = expected_scroll_q.pop_front();
          if (got_word.scroll_x !== want_word.scroll_x)
            report("scroll_x", want_word.scroll_x, got_word.scroll_x);
          if (got_word.scroll_y !== want_word.scroll_y)
            report("scroll_y", want_word.scroll_y, got_word.scroll_y);
          if (got_word.scroll_valid !== want_word.scroll_valid)
            report("scroll_valid", want_word.scroll_valid, got_word.scroll_valid);
          if (got_word.col_refresh !== want_word.col_refresh)
            report("col_refresh", want_word.col_refresh, got_word.col_refresh);
          if (got_word.col_index !== want_word.col_index)
            report("col_index", want_word.col_index, got_word.col_index);
          if (got_word.col_top_row !== want_word.col_top_row)
            report("col_top_row", want_word.col_top_row, got_word.col_top_row);
          if (got_word.row_refresh !== want_word.row_refresh)
            report("row_refresh", want_word.row_refresh, got_word.row_refresh);
          if (got_word.row_index !== want_word.row_index)
            report("row_index", want_word.row_index, got_word.row_index);
          if (got_word.row_left_col !== want_word.row_left_col)
            report("row_left_col", want_word.row_left_col, got_word.row_left_col);
          if (m_tdata[OutDataW-1:ResultW] !== '0)
            report("padding", '0, m_tdata[OutDataW-1:ResultW]);
        end
      end

      if (s_tvalid && s_tready) begin
        next_x = chase_axis(cam_x, s_tdata[PosW-1:0], zone_x, map_w, SCREEN_W);
        next_y = chase_axis(cam_y, s_tdata[2*PosW-1:PosW], zone_y, map_h, SCREEN_H);
        want_word = '0;
        want_word.scroll_x     = next_x;
        want_word.scroll_y     = next_y;
        want_word.scroll_valid = !suppress;
        tile_refresh(cam_x, next_x, SCREEN_W, want_word.col_refresh, want_word.col_index);
        if (want_word.col_refresh) want_word.col_top_row = next_y[TileW+2:3];
        tile_refresh(cam_y, next_y, SCREEN_H, want_word.row_refresh, want_word.row_index);
        if (want_word.row_refresh) want_word.row_left_col = next_x[TileW+2:3];
        cam_x = next_x;
        cam_y = next_y;
        expected_scroll_q.push_back(want_word);
      end

      words_pending <= expected_scroll_q.size();
    end
  end

endmodule

// File: bench/tb_dead_zone_scroll_camera_unit.sv
// Top of the scroll camera bench: clock, reset, stimulus, flow control and the verdict.
module tb_dead_zone_scroll_camera_unit;

  localparam int ScreenW  = dzsc_pkg::ScreenWDefault;
  localparam int ScreenH  = dzsc_pkg::ScreenHDefault;
  localparam int PosW     = dzsc_pkg::PosW;
  localparam int RegW     = dzsc_pkg::RegW;
  localparam int CfgIdxW  = dzsc_pkg::CfgIdxW;
  localparam int InDataW  = dzsc_pkg::InDataW;
  localparam int OutDataW = dzsc_pkg::OutDataW;

  // The register file stops at the scroll suppress bit; this index lands past the
  // end of the list and must leave every register alone.
  localparam logic [CfgIdxW-1:0] CfgIdxSpare = 3'd7;

  localparam int RandomPhases = 8;
  localparam int PhaseWords   = 92;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                s_tvalid  = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata   = '0;
  logic                m_tvalid;
  logic                m_tready  = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                cfg_we    = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [RegW-1:0]     cfg_data  = '0;

  int mismatch_count;
  int words_pending;

  // Flow control knobs, in percent of cycles.
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // The followed object walks in whole pixels; map size sets the range of most of its jumps.
  int walk_x = 0;
  int walk_y = 0;
  int map_w_px = 0;
  int map_h_px = 0;

  dead_zone_scroll_camera_unit #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH)
  ) uut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  dzsc_scroll_checker #(
    .SCREEN_W(ScreenW),
    .SCREEN_H(ScreenH)
  ) scroll_check (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .mismatch_count(mismatch_count),
    .words_pending(words_pending)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // The receiver drops tready at random; a single assignment per edge keeps it clean.
  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  // Offers one position word and returns at the edge where it is taken. The sender
  // may idle first; tvalid is only lowered while idling, so back-to-back words keep
  // it high without a glitch.
  task automatic send_pos(input logic [PosW-1:0] px, input logic [PosW-1:0] py);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {py, px};
    do @(posedge clk); while (!s_tready);
  endtask

  // Stops sending and waits for every predicted word to come back. The checker
  // publishes its count through a register, so the first edge is always waited out.
  task automatic wait_drained();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (words_pending != 0) @(posedge clk);
    // Waits past the two-register pipeline before touching registers.
    repeat (4) @(posedge clk);
  endtask

  // Writes all five registers back to back, then pokes the unused index with junk.
  task automatic apply_setting(input logic [RegW-1:0] zone_r, input logic [RegW-1:0] zone_b,
                               input logic [RegW-1:0] tiles_w, input logic [RegW-1:0] tiles_h,
                               input logic [RegW-1:0] suppress_data);
    cfg_we    <= 1'b1;
    cfg_index <= dzsc_pkg::CFG_ZONE_RIGHT_X;
    cfg_data  <= zone_r;
    @(posedge clk);
    cfg_index <= dzsc_pkg::CFG_ZONE_BOTTOM_Y;
    cfg_data  <= zone_b;
    @(posedge clk);
    cfg_index <= dzsc_pkg::CFG_MAP_WIDTH_TILES;
    cfg_data  <= tiles_w;
    @(posedge clk);
    cfg_index <= dzsc_pkg::CFG_MAP_HEIGHT_TILES;
    cfg_data  <= tiles_h;
    @(posedge clk);
    cfg_index <= dzsc_pkg::CFG_SCROLL_SUPPRESS;
    cfg_data  <= suppress_data;
    @(posedge clk);
    cfg_index <= CfgIdxSpare;
    cfg_data  <= RegW'($urandom);
    @(posedge clk);
    cfg_we   <= 1'b0;
    map_w_px = int'(tiles_w) * 8;
    map_h_px = int'(tiles_h) * 8;
  endtask

  // Mostly small drifts around the dead zone, so the camera keeps crossing tile
  // edges both ways; now and then a jump up to 200 pixels past the map or anywhere at all.
  function automatic int walk_step(input int pos, input int span);
    int roll;
    roll = $urandom_range(99);
    if (roll < 75) begin
      pos = pos + int'($urandom_range(40)) - 20;
    end else if (roll < 92) begin
      pos = int'($urandom_range(span + 200));
    end else begin
      pos = int'($urandom_range(4095));
    end
    if (pos < 0) pos = 0;
    if (pos > 4095) pos = 4095;
    return pos;
  endfunction

  task automatic run_walk(input int count);
    repeat (count) begin
      walk_x = walk_step(walk_x, map_w_px);
      walk_y = walk_step(walk_y, map_h_px);
      // The low nibble is the sub-pixel part and must not affect the camera.
      send_pos({12'(walk_x), 4'($urandom)}, {12'(walk_y), 4'($urandom)});
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Registers at their reset values: a zero-sized map pins the camera at zero.
    send_pos(16'h0000, 16'h0000);
    send_pos(16'hFFFF, 16'hFFFF);

    // Full-size map with the usual zone.
    wait_drained();
    apply_setting(8'd140, 8'd124, 8'd255, 8'd255, 8'h00);
    send_pos(16'hFFFF, 16'hFFFF);  // big forward jump, clamped at the map's far end
    send_pos(16'hFFF0, 16'hFFF0);  // tiny move, camera held by the clamp
    send_pos(16'h0000, 16'h0000);  // jump back; the move would go negative
    send_pos(16'h0A00, 16'h0900);  // past the far zone edge on both axes
    send_pos(16'h0A80, 16'h0980);  // one more tile forward, leading edge
    send_pos(16'h0800, 16'h0700);  // inside the zone, camera stays
    send_pos(16'h0100, 16'h0100);  // before the near edge, trailing edge, clamps to zero

    // Zone wider than the screen, map smaller than the screen, scroll withheld.
    wait_drained();
    apply_setting(8'd255, 8'd255, 8'd10, 8'd8, 8'h03);
    send_pos(16'h4000, 16'h4000);
    send_pos(16'h0000, 16'h0000);
    send_pos(16'hFFFF, 16'h0000);

    // Zero-width zone: the camera chases every move. The suppress write carries
    // only upper data bits, so scrolling comes back on.
    wait_drained();
    apply_setting(8'd0, 8'd0, 8'd255, 8'd255, 8'hFE);
    send_pos(16'h0010, 16'h0010);
    send_pos(16'h0FF0, 16'h0FF0);
    send_pos(16'h0000, 16'h0000);
    send_pos(16'hFFFF, 16'hFFFF);

    // Random walks, each phase under its own setting and flow-control mix.
    for (int phase = 0; phase < RandomPhases; phase++) begin
      wait_drained();
      case (phase)
        0: apply_setting(8'd140, 8'd124, 8'd255, 8'd255, 8'h00);
        1: apply_setting(8'd255, 8'd255, 8'd255, 8'd255, 8'h01);
        2: apply_setting(8'd0, 8'd0, 8'd200, 8'd180, 8'h00);
        4: apply_setting(8'd160, 8'd144, 8'd10, 8'd8, 8'h01);
        default: apply_setting(RegW'($urandom), RegW'($urandom),
                               RegW'($urandom_range(20, 255)),
                               RegW'($urandom_range(20, 255)), RegW'($urandom));
      endcase
      case (phase % 4)
        0: begin
          send_idle_pct  = 0;
          recv_stall_pct = 0;
        end
        1: begin
          send_idle_pct  = 67;
          recv_stall_pct = 0;
        end
        2: begin
          send_idle_pct  = 0;
          recv_stall_pct = 67;
        end
        default: begin
          send_idle_pct  = 22;
          recv_stall_pct = 22;
        end
      endcase
      run_walk(PhaseWords);
    end

    wait_drained();
    if (mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run.
  initial begin
    #3000000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
